### src/sfrd_pkg.sv
// Shared types and constants for the SYN flood rate detector.
// Used by the controller, the datapath and the top level; no dependencies.
package sfrd_pkg;

   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_EWMA_THRESHOLD   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SYN_THRESHOLD    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SMOOTHING_WEIGHT = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPIKE_LIMIT      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_IDLE_WINDOW      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_ALERT_HOLDOFF    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_SYN_FLOOR        = 3'd6;

   localparam logic [23:0] CNT_MAX = 24'hFFFFFF;
   localparam logic [16:0] ALPHA_ONE = 17'd65536;

   typedef struct packed {
      logic        valid;
      logic [31:0] tag;
      logic [31:0] last_seen;
      logic [23:0] syn_cnt;
      logic [23:0] synack_cnt;
      logic [31:0] average;
      logic        started;
      logic [31:0] prior;
      logic        alert_seen;
      logic [31:0] last_alert;
   } entry_type;

   typedef struct packed {
      logic clear;
      logic load;
      logic prep;
      logic mul1;
      logic mul2;
      logic sum;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic clear_done;
      logic div_done;
   } status_type;

endpackage

### src/sfrd_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on nothing outside this file.
module sfrd_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] numer,
   input  logic [23:0] denom,
   output logic        done,
   output logic [31:0] quot
);
   logic [31:0] num_ff, num_in;
   logic [23:0] rem_ff, rem_in;
   logic [23:0] den_ff;
   logic [4:0]  cnt_ff, cnt_in;
   logic        run_ff, run_in;
   logic        done_ff, done_in;
   logic [24:0] trial;
   logic        fits;

   always_comb begin
      trial = {rem_ff, num_ff[31]};
      fits = trial >= {1'b0, den_ff};
      num_in = num_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      run_in = run_ff;
      done_in = 1'b0;
      if (start) begin
         num_in = numer;
         rem_in = '0;
         cnt_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         num_in = {num_ff[30:0], fits};
         rem_in = fits ? 24'(trial - {1'b0, den_ff}) : trial[23:0];
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            run_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         run_ff <= run_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      if (start) begin
         den_ff <= denom;
      end
   end

   assign done = done_ff;
   assign quot = num_ff;
endmodule

### src/sfrd_dp.sv
// Datapath: configuration registers, source table memory, divider and EWMA math.
// Depends on sfrd_pkg and sfrd_div.
module sfrd_dp
   import sfrd_pkg::*;
#(
   parameter int TABLE_ENTRIES = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   output status_type            status,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data,
   input  logic [31:0]           req_source_address,
   input  logic                  req_syn_flag,
   input  logic                  req_ack_flag,
   input  logic [31:0]           req_now_seconds,
   output logic [31:0]           rsp_echo_address,
   output logic                  rsp_spike_warning,
   output logic                  rsp_flood_alert,
   output logic [31:0]           rsp_smoothed_ratio,
   output logic [31:0]           rsp_previous_ratio,
   output logic [23:0]           rsp_syn_total
);
   localparam int IDX_W = $clog2(TABLE_ENTRIES);

   // Configuration registers.
   logic [31:0] ewma_thr_ff, spike_lim_ff;
   logic [23:0] syn_thr_ff, floor_ff;
   logic [16:0] weight_ff;
   logic [15:0] idle_ff, holdoff_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ewma_thr_ff  <= 32'd128000;
         syn_thr_ff   <= 24'd1000;
         weight_ff    <= 17'd6554;
         spike_lim_ff <= 32'd1280;
         idle_ff      <= 16'd60;
         holdoff_ff   <= 16'd120;
         floor_ff     <= 24'd10;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_EWMA_THRESHOLD:   ewma_thr_ff  <= csr_write_data;
            CSR_SYN_THRESHOLD:    syn_thr_ff   <= csr_write_data[23:0];
            CSR_SMOOTHING_WEIGHT: weight_ff    <= csr_write_data[16:0];
            CSR_SPIKE_LIMIT:      spike_lim_ff <= csr_write_data;
            CSR_IDLE_WINDOW:      idle_ff      <= csr_write_data[15:0];
            CSR_ALERT_HOLDOFF:    holdoff_ff   <= csr_write_data[15:0];
            CSR_SYN_FLOOR:        floor_ff     <= csr_write_data[23:0];
            default: ;
         endcase
      end
   end

   // Transaction capture.
   logic [31:0] addr_ff, now_ff;
   logic        syn_ff, ack_ff;
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         addr_ff <= req_source_address;
         now_ff  <= req_now_seconds;
         syn_ff  <= req_syn_flag;
         ack_ff  <= req_ack_flag;
      end
   end

   // Table memory and clearing sweep.
   entry_type mem [TABLE_ENTRIES];
   entry_type rd_ff, wr_entry;
   logic [IDX_W-1:0] clr_ff, idx, wr_idx;
   logic             mem_we;

   assign idx = addr_ff[IDX_W-1:0];
   assign mem_we = cmd.clear | cmd.finish;
   assign wr_idx = cmd.clear ? clr_ff : idx;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clear) begin
         clr_ff <= clr_ff + 1'b1;
      end
   end
   assign status.clear_done = cmd.clear && (clr_ff == IDX_W'(TABLE_ENTRIES - 1));

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_idx] <= wr_entry;
      end
      rd_ff <= mem[idx];
   end

   // Entry preparation: hit check, idle timeout and counting.
   logic [23:0] syn_cnt_ff, sack_cnt_ff, syn_cnt_in, sack_cnt_in;
   logic [31:0] old_avg_ff, prior_ff, lat_ff, old_avg_in, prior_in, lat_in;
   logic        started_ff, aseen_ff, started_in, aseen_in;
   logic        hit, timeout;

   always_comb begin
      hit = rd_ff.valid && (rd_ff.tag == addr_ff);
      timeout = (now_ff - rd_ff.last_seen) > {16'd0, idle_ff};
      syn_cnt_in  = rd_ff.syn_cnt;
      sack_cnt_in = rd_ff.synack_cnt;
      old_avg_in  = rd_ff.average;
      prior_in    = rd_ff.prior;
      started_in  = rd_ff.started;
      aseen_in    = rd_ff.alert_seen;
      lat_in      = rd_ff.last_alert;
      if (!hit) begin
         syn_cnt_in = '0; sack_cnt_in = '0; old_avg_in = '0; prior_in = '0;
         started_in = 1'b0; aseen_in = 1'b0; lat_in = '0;
      end else if (timeout) begin
         syn_cnt_in = '0; sack_cnt_in = '0; old_avg_in = '0; prior_in = '0;
      end
      if (syn_ff && !ack_ff && syn_cnt_in != CNT_MAX) begin
         syn_cnt_in = syn_cnt_in + 24'd1;
      end else if (syn_ff && ack_ff && sack_cnt_in != CNT_MAX) begin
         sack_cnt_in = sack_cnt_in + 24'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.prep) begin
         syn_cnt_ff  <= syn_cnt_in;
         sack_cnt_ff <= sack_cnt_in;
         old_avg_ff  <= old_avg_in;
         prior_ff    <= prior_in;
         started_ff  <= started_in;
         aseen_ff    <= aseen_in;
         lat_ff      <= lat_in;
      end
   end

   // Ratio divider.
   logic [31:0] quot;
   sfrd_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.prep),
      .numer ({syn_cnt_in, 8'd0}),
      .denom (sack_cnt_in),
      .done  (status.div_done),
      .quot  (quot)
   );

   // EWMA.
   logic [16:0] alpha;
   logic [31:0] ratio, ratio_ff, avg_ff;
   logic [48:0] p1_ff, p2_ff;
   logic [49:0] acc;
   logic [33:0] acc_sh;

   assign alpha = (weight_ff > ALPHA_ONE) ? ALPHA_ONE : weight_ff;
   always_comb begin
      if (sack_cnt_ff != 24'd0) begin
         ratio = quot;
      end else if (syn_cnt_ff > floor_ff) begin
         ratio = {syn_cnt_ff, 8'd0};
      end else begin
         ratio = '0;
      end
      acc = {1'b0, p1_ff} + {1'b0, p2_ff} + 50'd32768;
      acc_sh = acc[49:16];
   end

   always_ff @(posedge clock) begin
      if (cmd.mul1) begin
         ratio_ff <= ratio;
         p1_ff <= 49'(alpha * ratio);
      end
      if (cmd.mul2) begin
         p2_ff <= 49'(17'(ALPHA_ONE - alpha) * old_avg_ff);
      end
      if (cmd.sum) begin
         if (!started_ff) begin
            avg_ff <= ratio_ff;
         end else if (acc_sh[33:32] != 2'd0) begin
            avg_ff <= 32'hFFFFFFFF;
         end else begin
            avg_ff <= acc_sh[31:0];
         end
      end
   end

   // Spike, alert and write-back.
   logic [31:0] diff;
   logic        spike, alert;
   always_comb begin
      diff = (avg_ff >= prior_ff) ? avg_ff - prior_ff : prior_ff - avg_ff;
      spike = diff > spike_lim_ff;
      alert = (avg_ff > ewma_thr_ff) && (syn_cnt_ff > syn_thr_ff)
              && !(aseen_ff && ((now_ff - lat_ff) < {16'd0, holdoff_ff}));
      wr_entry = '0;
      if (!cmd.clear) begin
         wr_entry.valid      = 1'b1;
         wr_entry.tag        = addr_ff;
         wr_entry.last_seen  = now_ff;
         wr_entry.syn_cnt    = syn_cnt_ff;
         wr_entry.synack_cnt = sack_cnt_ff;
         wr_entry.average    = avg_ff;
         wr_entry.started    = 1'b1;
         wr_entry.prior      = avg_ff;
         wr_entry.alert_seen = aseen_ff | alert;
         wr_entry.last_alert = alert ? now_ff : lat_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_echo_address   <= addr_ff;
         rsp_spike_warning  <= spike;
         rsp_flood_alert    <= alert;
         rsp_smoothed_ratio <= avg_ff;
         rsp_previous_ratio <= prior_ff;
         rsp_syn_total      <= syn_cnt_ff;
      end
   end
endmodule

### src/sfrd_ctrl.sv
// Controller state machine sequencing the table sweep and per-packet steps.
// Depends on sfrd_pkg.
module sfrd_ctrl
   import sfrd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  status_type status,
   output cmd_type    cmd,
   output logic       busy,
   output logic       rsp_valid
);
   localparam logic [3:0] ST_CLEAR  = 4'd0;
   localparam logic [3:0] ST_IDLE   = 4'd1;
   localparam logic [3:0] ST_READ   = 4'd2;
   localparam logic [3:0] ST_PREP   = 4'd3;
   localparam logic [3:0] ST_DIV    = 4'd4;
   localparam logic [3:0] ST_MUL1   = 4'd5;
   localparam logic [3:0] ST_MUL2   = 4'd6;
   localparam logic [3:0] ST_SUM    = 4'd7;
   localparam logic [3:0] ST_FINISH = 4'd8;

   logic [3:0] state_ff, state_in;
   logic       valid_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR:  if (status.clear_done) state_in = ST_IDLE;
         ST_IDLE:   if (start) state_in = ST_READ;
         ST_READ:   state_in = ST_PREP;
         ST_PREP:   state_in = ST_DIV;
         ST_DIV:    if (status.div_done) state_in = ST_MUL1;
         ST_MUL1:   state_in = ST_MUL2;
         ST_MUL2:   state_in = ST_SUM;
         ST_SUM:    state_in = ST_FINISH;
         ST_FINISH: state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= (state_ff == ST_FINISH);
      end
   end

   assign busy = (state_ff != ST_IDLE);
   assign rsp_valid = valid_ff;
   assign cmd.clear  = (state_ff == ST_CLEAR);
   assign cmd.load   = (state_ff == ST_IDLE) && start;
   assign cmd.prep   = (state_ff == ST_PREP);
   assign cmd.mul1   = (state_ff == ST_MUL1);
   assign cmd.mul2   = (state_ff == ST_MUL2);
   assign cmd.sum    = (state_ff == ST_SUM);
   assign cmd.finish = (state_ff == ST_FINISH);
endmodule

### src/syn_flood_rate_detector.sv
// One transaction is in flight at a time: start is taken only while busy is low, and busy
// stays high until the write-back; the time each transaction takes is dominated by the
// stretch of the bit-serial ratio divider.
// After reset the block sweeps the source table with busy high before it accepts a
// transaction; results are strobed for one cycle, no receiver stall.
// Depends on sfrd_pkg, sfrd_ctrl, sfrd_dp and sfrd_div.
module syn_flood_rate_detector
   import sfrd_pkg::*;
#(
   // Number of table slots; must be a power of two so the slot index is the
   // low address bits.
   parameter int TABLE_ENTRIES = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [31:0]           req_source_address,
   input  logic                  req_syn_flag,
   input  logic                  req_ack_flag,
   input  logic [31:0]           req_now_seconds,
   output logic                  rsp_valid,
   output logic [31:0]           rsp_echo_address,
   output logic                  rsp_spike_warning,
   output logic                  rsp_flood_alert,
   output logic [31:0]           rsp_smoothed_ratio,
   output logic [31:0]           rsp_previous_ratio,
   output logic [23:0]           rsp_syn_total,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data
);
   cmd_type    cmd;
   status_type status;

   // The controller steps each transaction through table read, count update,
   // division, the two EWMA products, the sum and the write-back.
   sfrd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   // The datapath holds the table memory, configuration and arithmetic.
   sfrd_dp #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data),
      .req_source_address (req_source_address),
      .req_syn_flag       (req_syn_flag),
      .req_ack_flag       (req_ack_flag),
      .req_now_seconds    (req_now_seconds),
      .rsp_echo_address   (rsp_echo_address),
      .rsp_spike_warning  (rsp_spike_warning),
      .rsp_flood_alert    (rsp_flood_alert),
      .rsp_smoothed_ratio (rsp_smoothed_ratio),
      .rsp_previous_ratio (rsp_previous_ratio),
      .rsp_syn_total      (rsp_syn_total)
   );
endmodule

### src/sfrd_checker.sv
// Port-level checks for the SYN flood rate detector, bound to the top level.
// Depends on syn_flood_rate_detector.
module sfrd_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid
);
   a_reset_sweep: assert property (@(posedge clock) reset |=> busy)
      else $error("table sweep not running after reset");
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted transaction did not raise busy");
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobed while still busy");
endmodule

bind syn_flood_rate_detector sfrd_checker u_sfrd_checker (.*);
